// File: hdl/gvn_pkg.sv
// Shared constants, types and helpers for the grid vertex normal stream.
package gvn_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + 2;
    localparam int MEM_DEPTH   = 3 * MAX_COLUMNS;
    localparam int CFG_W       = 11;
    localparam int POS_W       = 48;
    localparam int NRM_W       = 16;
    localparam int VIDX_W      = 20;

    // Register indexes of the configuration port
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef logic [POS_W-1:0] t_pos;

    // Four neighbour positions handed to the normal unit
    typedef struct packed {
        t_pos bot;
        t_pos top;
        t_pos rgt;
        t_pos lft;
    } t_nrm_req;

    // Finished normal
    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
        logic                    degenerate;
    } t_nrm_res;

    // Add two row slots modulo three
    function automatic logic [1:0] mod3_add(input logic [1:0] s, input logic [1:0] k);
        logic [2:0] t;
        t = {1'b0, s} + {1'b0, k};
        if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// File: hdl/grid_vertex_normal_stream_core.sv
// Top level: input sequencing, neighbour fetch, result register.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready        tdata: pos_x, pos_y, pos_z
//  m_axis    out  m_axis_tvalid/tready        tdata: normal_x/y/z, vertex_index;
//                                             tuser: degenerate, frame_done; tlast
//  cfg       in   i_cfg_we                    index 0 grid_columns, 1 grid_rows
//
// An item is written to the line buffer on acceptance; each normal it releases
// (up to three) takes four buffer reads, then the cross product and normalising
// shift, the square root and the division of each component in the iterative
// normal unit. Items that release none go straight back to accepting.
// Reset is synchronous; the buffer needs no clearing. A stalled output holds
// its word while the next item is already being accepted and processed.
module grid_vertex_normal_stream_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [47:0]                  s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [71:0]                  m_axis_tdata,   // normal_x, normal_y, normal_z,
                                                         // vertex_index, zero fill
    output logic [1:0]                   m_axis_tuser,   // degenerate, frame_done
    output logic                         m_axis_tlast,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [gvn_pkg::CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_NEXT, ST_READ, ST_CALC, ST_OUT
    } t_state;

    localparam int CW = gvn_pkg::COL_W;
    localparam int RW = gvn_pkg::ROW_W;
    localparam int AW = gvn_pkg::ADDR_W;

    t_state                       r_state;
    logic [gvn_pkg::CFG_W-1:0]    r_cols;
    logic [gvn_pkg::CFG_W-1:0]    r_rows;
    logic [CW-1:0]                r_col;
    logic [RW-1:0]                r_row;
    logic [1:0]                   r_slot;
    logic [2:0]                   r_pend;
    logic [RW-1:0]                r_jr;
    logic [CW-1:0]                r_jc;
    logic [1:0]                   r_js;
    logic [AW-1:0]                r_addr [4];
    logic [2:0]                   r_cnt;
    gvn_pkg::t_pos                r_pos [4];
    logic [gvn_pkg::VIDX_W-1:0]   r_vidx;
    logic                         r_fdone;
    logic                         r_last;
    logic                         r_start;
    gvn_pkg::t_nrm_res            r_res;
    logic                         r_out_valid;
    logic [71:0]                  r_out_data;
    logic [1:0]                   r_out_user;
    logic                         r_out_last;

    logic [gvn_pkg::CFG_W-1:0]    w_cols;
    logic [gvn_pkg::CFG_W-1:0]    w_rows;
    logic                         w_accept;
    logic                         w_last_col;
    logic                         w_last_row;
    logic [1:0]                   w_sel;
    logic [RW-1:0]                w_vr;
    logic [CW-1:0]                w_vc;
    logic [1:0]                   w_sv;
    logic [1:0]                   w_st;
    logic [1:0]                   w_sb;
    logic                         w_jlast;
    logic                         w_redge;
    logic                         w_bedge;
    logic [AW-1:0]                w_ctr;
    logic [AW-1:0]                w_raddr;
    gvn_pkg::t_pos                w_rdata;
    gvn_pkg::t_nrm_req            w_req;
    logic                         w_done;
    gvn_pkg::t_nrm_res            w_res;
    logic [20:0]                  w_vidx;

    // Clamp the size registers
    always_comb begin
        w_cols = r_cols;
        if (r_cols == '0) begin
            w_cols = 11'd1;
        end else if (r_cols > 11'(gvn_pkg::MAX_COLUMNS)) begin
            w_cols = 11'(gvn_pkg::MAX_COLUMNS);
        end
        w_rows = r_rows;
        if (r_rows == '0) begin
            w_rows = 11'd1;
        end else if (r_rows > 11'(gvn_pkg::MAX_ROWS)) begin
            w_rows = 11'(gvn_pkg::MAX_ROWS);
        end
    end

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_last_col = ({1'b0, r_col} + 11'd1) >= w_cols;
    assign w_last_row = ({1'b0, r_row} + 11'd1) >= w_rows;

    // Choose the next pending normal: above row first, then row flush
    always_comb begin
        priority if (r_pend[0]) begin
            w_sel   = 2'd0;
            w_jlast = !r_pend[1] && !r_pend[2];
        end else if (r_pend[1]) begin
            w_sel   = 2'd1;
            w_jlast = !r_pend[2];
        end else begin
            w_sel   = 2'd2;
            w_jlast = 1'b1;
        end
        w_vr = (w_sel == 2'd0) ? r_jr - RW'(1) : r_jr;
        w_vc = (w_sel == 2'd1) ? r_jc - CW'(1) : r_jc;
        if (w_sel == 2'd0) begin
            w_sv = gvn_pkg::mod3_add(r_js, 2'd2);
            w_st = gvn_pkg::mod3_add(r_js, 2'd1);
        end else begin
            w_sv = r_js;
            w_st = gvn_pkg::mod3_add(r_js, 2'd2);
        end
        w_sb    = r_js;
        w_redge = ({1'b0, w_vc} + 11'd1) >= w_cols;
        w_bedge = ({1'b0, w_vr} + 11'd1) >= w_rows;
        w_ctr   = {w_sv, w_vc};
        w_vidx  = 21'(w_vr) * 21'(w_cols) + 21'(w_vc);
    end

    assign w_raddr = r_addr[r_cnt[1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cols      <= 11'd64;
            r_rows      <= 11'd64;
            r_col       <= '0;
            r_row       <= '0;
            r_slot      <= '0;
            r_pend      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // Load a new output word when free, drop it once taken
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                // Take an item, list the normals it releases, advance the counters
                ST_IDLE: begin
                    if (w_accept) begin
                        r_jr    <= r_row;
                        r_jc    <= r_col;
                        r_js    <= r_slot;
                        r_pend  <= {w_last_row && w_last_col,
                                    w_last_row && (r_col != '0),
                                    r_row != '0};
                        r_state <= ST_NEXT;
                        if (w_last_col) begin
                            r_col <= '0;
                            if (w_last_row) begin
                                r_row  <= '0;
                                r_slot <= '0;
                            end else begin
                                r_row  <= r_row + RW'(1);
                                r_slot <= gvn_pkg::mod3_add(r_slot, 2'd1);
                            end
                        end else begin
                            r_col <= r_col + CW'(1);
                        end
                    end
                end
                // Set up neighbour addresses, substituting the centre at edges; idle when none pend
                ST_NEXT: begin
                    if (r_pend == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_addr[0] <= (w_vc == '0) ? w_ctr : {w_sv, w_vc - CW'(1)};
                        r_addr[1] <= w_redge ? w_ctr : {w_sv, w_vc + CW'(1)};
                        r_addr[2] <= (w_vr == '0) ? w_ctr : {w_st, w_vc};
                        r_addr[3] <= w_bedge ? w_ctr : {w_sb, w_vc};
                        r_vidx    <= w_vidx[gvn_pkg::VIDX_W-1:0];
                        r_fdone   <= w_redge && w_bedge;
                        r_last    <= w_jlast;
                        r_pend[w_sel] <= 1'b0;
                        r_cnt     <= '0;
                        r_state   <= ST_READ;
                    end
                end
                // Issue four reads, capturing each word from the registered read port
                ST_READ: begin
                    if (r_cnt != 3'd0) begin
                        r_pos[2'(r_cnt - 3'd1)] <= w_rdata;
                    end
                    if (r_cnt == 3'd4) begin
                        r_start <= 1'b1;
                        r_state <= ST_CALC;
                    end
                    r_cnt <= r_cnt + 3'd1;
                end
                ST_CALC: begin
                    if (w_done) begin
                        r_res   <= w_res;
                        r_state <= ST_OUT;
                    end
                end
                // Load the output word once the register is free
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= {4'd0, r_vidx, r_res.nz, r_res.ny, r_res.nx};
                        r_out_user  <= {r_fdone, r_res.degenerate};
                        r_out_last  <= r_last;
                        r_state     <= ST_NEXT;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // Size writes restart the frame
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    gvn_pkg::REG_COLUMNS: r_cols <= i_cfg_data;
                    gvn_pkg::REG_ROWS:    r_rows <= i_cfg_data;
                endcase
                r_col  <= '0;
                r_row  <= '0;
                r_slot <= '0;
            end
        end
    end

    assign w_req.lft = r_pos[0];
    assign w_req.rgt = r_pos[1];
    assign w_req.top = r_pos[2];
    assign w_req.bot = r_pos[3];

    gvn_row_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr ({r_slot, r_col}),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gvn_normal_unit u_nrm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot != 2'd3) else $error("row slot out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_col} < w_cols) else $error("column counter beyond row");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("frame end not last of run");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:0] == '0)
        else $error("degenerate normal not zero");

    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                          $signed(m_axis_tdata[15:0]) >= -16'sd16384)
        else $error("normal component out of range");
`endif

endmodule

// File: hdl/gvn_row_mem.sv
// Three-row line buffer: one write port, one registered read port.
module gvn_row_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [gvn_pkg::ADDR_W-1:0]  i_waddr,
    input  gvn_pkg::t_pos               i_wdata,
    input  logic [gvn_pkg::ADDR_W-1:0]  i_raddr,
    output gvn_pkg::t_pos               o_rdata
);

    gvn_pkg::t_pos r_mem [gvn_pkg::MEM_DEPTH];
    gvn_pkg::t_pos r_rdata;

    // Write the incoming word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/gvn_normal_unit.sv
// Cross product, normalising shift, square root and division for one normal.
module gvn_normal_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  gvn_pkg::t_nrm_req i_req,
    output logic              o_done,
    output gvn_pkg::t_nrm_res o_res
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_MAG, S_NORM, S_SQ, S_SQRT, S_DVINIT, S_DIV
    } t_state;

    t_state                   r_state;
    logic                     r_done;
    logic signed [16:0]       r_a [3];
    logic signed [16:0]       r_b [3];
    logic [2:0]               r_k;
    logic signed [33:0]       r_prod;
    logic signed [34:0]       r_n [3];
    logic                     r_neg [3];
    logic [34:0]              r_mag [3];
    logic [41:0]              r_sq;
    logic [43:0]              r_l;
    logic [59:0]              r_rad;
    logic [30:0]              r_rem;
    logic [29:0]              r_root;
    logic [4:0]               r_cnt;
    logic [43:0]              r_num;
    logic [43:0]              r_div;
    logic [13:0]              r_q;
    logic [1:0]               r_j;
    logic signed [15:0]       r_nrm [3];
    logic                     r_degen;

    logic signed [16:0]       w_opa;
    logic signed [16:0]       w_opb;
    logic [2:0]               w_p;
    logic [34:0]              w_max;
    logic [34:0]              w_abs [3];
    logic [32:0]              w_rem2;
    logic [32:0]              w_trial;
    logic                     w_ge;
    logic [15:0]              w_qv;

    // Pick multiplier operands for each partial product
    always_comb begin
        unique case (r_k)
            3'd0: begin w_opa = r_a[1]; w_opb = r_b[2]; end
            3'd1: begin w_opa = r_a[2]; w_opb = r_b[1]; end
            3'd2: begin w_opa = r_a[2]; w_opb = r_b[0]; end
            3'd3: begin w_opa = r_a[0]; w_opb = r_b[2]; end
            3'd4: begin w_opa = r_a[0]; w_opb = r_b[1]; end
            3'd5: begin w_opa = r_a[1]; w_opb = r_b[0]; end
            default: begin w_opa = r_a[0]; w_opb = r_b[0]; end
        endcase
    end

    assign w_p = r_k - 3'd1;

    // Magnitudes and their maximum
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_n[i][34] ? 35'(-r_n[i]) : 35'(r_n[i]);
        end
        w_max = r_mag[0];
        if (r_mag[1] > w_max) begin
            w_max = r_mag[1];
        end
        if (r_mag[2] > w_max) begin
            w_max = r_mag[2];
        end
    end

    // One square-root digit
    assign w_rem2  = {r_rem, r_rad[59:58]};
    assign w_trial = {1'b0, r_root, 2'b01};

    // One quotient bit
    assign w_ge = (r_num >= r_div);
    assign w_qv = {1'b0, r_q, w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a[0] <= 17'($signed(i_req.bot[15:0]))  - 17'($signed(i_req.top[15:0]));
                        r_a[1] <= 17'($signed(i_req.bot[31:16])) - 17'($signed(i_req.top[31:16]));
                        r_a[2] <= 17'($signed(i_req.bot[47:32])) - 17'($signed(i_req.top[47:32]));
                        r_b[0] <= 17'($signed(i_req.rgt[15:0]))  - 17'($signed(i_req.lft[15:0]));
                        r_b[1] <= 17'($signed(i_req.rgt[31:16])) - 17'($signed(i_req.lft[31:16]));
                        r_b[2] <= 17'($signed(i_req.rgt[47:32])) - 17'($signed(i_req.lft[47:32]));
                        r_k     <= 3'd0;
                        r_state <= S_MUL;
                    end
                end
                // Six products through one multiplier, each combined in the next cycle
                S_MUL: begin
                    if (r_k != 3'd6) begin
                        r_prod <= w_opa * w_opb;
                    end
                    if (r_k != 3'd0) begin
                        if (!w_p[0]) begin
                            r_n[w_p[2:1]] <= 35'(r_prod);
                        end else begin
                            r_n[w_p[2:1]] <= r_n[w_p[2:1]] - 35'(r_prod);
                        end
                    end
                    if (r_k == 3'd6) begin
                        r_state <= S_MAG;
                    end
                    r_k <= r_k + 3'd1;
                end
                // Split into sign and magnitude; catch the zero vector
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= r_n[i][34];
                        r_mag[i] <= w_abs[i];
                    end
                    if ((r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0)) begin
                        for (int i = 0; i < 3; i++) begin
                            r_nrm[i] <= '0;
                        end
                        r_degen <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_NORM;
                    end
                end
                // Shift one bit a cycle until the largest lies in [2^20, 2^21)
                S_NORM: begin
                    if (w_max[34:21] != '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else if (!w_max[20]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] << 1;
                        end
                    end else begin
                        r_k     <= 3'd0;
                        r_l     <= '0;
                        r_state <= S_SQ;
                    end
                end
                // Sum of squares, one square a cycle
                S_SQ: begin
                    if (r_k != 3'd3) begin
                        r_sq <= r_mag[r_k[1:0]][20:0] * r_mag[r_k[1:0]][20:0];
                    end
                    if (r_k != 3'd0) begin
                        r_l <= r_l + 44'(r_sq);
                    end
                    if (r_k == 3'd3) begin
                        r_rad   <= {r_l + 44'(r_sq), 16'd0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                    r_k <= r_k + 3'd1;
                end
                // Restoring square root, one result bit a cycle
                S_SQRT: begin
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= 31'(w_rem2 - w_trial);
                        r_root <= {r_root[28:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2[30:0];
                        r_root <= {r_root[28:0], 1'b0};
                    end
                    r_rad <= r_rad << 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd29) begin
                        r_j     <= 2'd0;
                        r_state <= S_DVINIT;
                    end
                end
                // Load the rounded numerator for one component
                S_DVINIT: begin
                    r_num   <= {1'b0, r_mag[r_j][20:0], 22'd0} + 44'(r_root >> 1);
                    r_div   <= {r_root, 14'd0};
                    r_q     <= '0;
                    r_cnt   <= 5'd14;
                    r_state <= S_DIV;
                end
                // Long division, one quotient bit a cycle
                S_DIV: begin
                    if (w_ge) begin
                        r_num <= r_num - r_div;
                    end
                    r_div <= r_div >> 1;
                    r_q   <= {r_q[12:0], w_ge};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_nrm[r_j] <= r_neg[r_j] ? $signed(-w_qv) : $signed(w_qv);
                        if (r_j == 2'd2) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_DVINIT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_res.nx       = r_nrm[0];
    assign o_res.ny       = r_nrm[1];
    assign o_res.nz       = r_nrm[2];
    assign o_res.degenerate = r_degen;

endmodule
